// ===== hw/rtl/e2q_pkg.sv =====
`timescale 1ns / 1ps

package e2q_pkg;

    localparam int SampleWidthDefault = 16;
    localparam int CordicSteps = 30;
    localparam int StepIdxW = 5;
    // CORDIC datapath: Q30 values; folded z and x,y stay within +-2^31
    localparam int CordW = 34;
    localparam int ProdW = 32;

    localparam logic signed [CordW-1:0] CordicGain = 34'sd652032874;
    localparam logic signed [CordW-1:0] HalfPi     = 34'sd1686629713;
    localparam logic signed [CordW-1:0] PiQ30      = 34'sd3373259426;

    typedef struct packed {
        logic [SampleWidthDefault-1:0] roll;
        logic [SampleWidthDefault-1:0] pitch;
        logic [SampleWidthDefault-1:0] yaw;
    } in_item_t;

    typedef struct packed {
        logic [SampleWidthDefault-1:0] q_scalar;
        logic [SampleWidthDefault-1:0] q_x;
        logic [SampleWidthDefault-1:0] q_y;
        logic [SampleWidthDefault-1:0] q_z;
    } out_item_t;

    // one angle in flight through the rotation chain
    typedef struct packed {
        logic signed [CordW-1:0] x;
        logic signed [CordW-1:0] y;
        logic signed [CordW-1:0] z;
        logic                    neg;
    } rot_t;

    function automatic logic signed [CordW-1:0] atan_q30(input logic [StepIdxW-1:0] i);
        logic signed [CordW-1:0] r;
        begin
            case (i)
                5'd0:  r = 34'sh03243F6A8;
                5'd1:  r = 34'sh01DAC6705;
                5'd2:  r = 34'sh00FADBAFC;
                5'd3:  r = 34'sh007F56EA6;
                5'd4:  r = 34'sh003FEAB76;
                5'd5:  r = 34'sh001FFD55B;
                5'd6:  r = 34'sh000FFFAAA;
                5'd7:  r = 34'sh0007FFF55;
                5'd8:  r = 34'sh0003FFFEA;
                5'd9:  r = 34'sh0001FFFFD;
                5'd10: r = 34'sh0000FFFFF;
                5'd11: r = 34'sh00007FFFF;
                5'd12: r = 34'sh00003FFFF;
                5'd13: r = 34'sh00001FFFF;
                5'd14: r = 34'sh00000FFFF;
                5'd15: r = 34'sh000007FFF;
                5'd16: r = 34'sh000003FFF;
                5'd17: r = 34'sh000001FFF;
                5'd18: r = 34'sh000000FFF;
                5'd19: r = 34'sh0000007FF;
                5'd20: r = 34'sh0000003FF;
                5'd21: r = 34'sh0000001FF;
                5'd22: r = 34'sh0000000FF;
                5'd23: r = 34'sh00000007F;
                5'd24: r = 34'sh00000003F;
                5'd25: r = 34'sh00000001F;
                5'd26: r = 34'sh00000000F;
                5'd27: r = 34'sh000000007;
                5'd28: r = 34'sh000000003;
                5'd29: r = 34'sh000000001;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== hw/rtl/e2q_cordic_cell.sv =====
`timescale 1ns / 1ps

module e2q_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic              clk,
    input  logic              en,
    input  e2q_pkg::rot_t     din,
    output e2q_pkg::rot_t     dout
);

    e2q_pkg::rot_t r_next;
    e2q_pkg::rot_t r_reg;
    logic signed [e2q_pkg::CordW-1:0] dx;
    logic signed [e2q_pkg::CordW-1:0] dy;
    logic signed [e2q_pkg::CordW-1:0] at;

    assign dx = din.y >>> STEP;
    assign dy = din.x >>> STEP;
    assign at = e2q_pkg::atan_q30(e2q_pkg::StepIdxW'(STEP));

    always_comb
    begin
        r_next.neg = din.neg;
        if (!din.z[e2q_pkg::CordW-1])
        begin
            r_next.x = din.x - dx;
            r_next.y = din.y + dy;
            r_next.z = din.z - at;
        end
        else
        begin
            r_next.x = din.x + dx;
            r_next.y = din.y - dy;
            r_next.z = din.z + at;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg <= r_next;
        end
    end

    assign dout = r_reg;

endmodule

// ===== hw/rtl/e2q_sincos.sv =====
`timescale 1ns / 1ps

module e2q_sincos #(
    parameter int SAMPLE_WIDTH = e2q_pkg::SampleWidthDefault
) (
    input  logic                               clk,
    input  logic                               en,
    input  logic [SAMPLE_WIDTH-1:0]            angle,
    output logic signed [e2q_pkg::ProdW-1:0]   cos_h,
    output logic signed [e2q_pkg::ProdW-1:0]   sin_h
);

    localparam int N = e2q_pkg::CordicSteps;
    localparam int W = e2q_pkg::CordW;

    e2q_pkg::rot_t fold_next;
    e2q_pkg::rot_t fold_reg;
    e2q_pkg::rot_t chain [N+1];
    logic signed [W-1:0] z0;
    logic signed [e2q_pkg::ProdW-1:0] c_next;
    logic signed [e2q_pkg::ProdW-1:0] s_next;
    logic signed [e2q_pkg::ProdW-1:0] c_reg;
    logic signed [e2q_pkg::ProdW-1:0] s_reg;

    // raw angle at scale 2^-(SAMPLE_WIDTH-2) is the half angle; move to Q30
    assign z0 = W'($signed(angle)) <<< (32 - SAMPLE_WIDTH);

    always_comb
    begin
        fold_next.x = e2q_pkg::CordicGain;
        fold_next.y = '0;
        fold_next.z = z0;
        fold_next.neg = 1'b0;
        if (z0 > e2q_pkg::HalfPi)
        begin
            fold_next.z = z0 - e2q_pkg::PiQ30;
            fold_next.neg = 1'b1;
        end
        else if (z0 < -e2q_pkg::HalfPi)
        begin
            fold_next.z = z0 + e2q_pkg::PiQ30;
            fold_next.neg = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fold_reg <= fold_next;
        end
    end

    assign chain[0] = fold_reg;

    for (genvar g = 0; g < N; g++)
    begin : g_cell
        e2q_cordic_cell #(.STEP(g)) u_cell (
            .clk  (clk),
            .en   (en),
            .din  (chain[g]),
            .dout (chain[g+1])
        );
    end

    // final magnitudes stay within +-2^30, so 32 bits hold them
    always_comb
    begin
        c_next = e2q_pkg::ProdW'(chain[N].x);
        s_next = e2q_pkg::ProdW'(chain[N].y);
        if (chain[N].neg)
        begin
            c_next = -c_next;
            s_next = -s_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg <= c_next;
            s_reg <= s_next;
        end
    end

    assign cos_h = c_reg;
    assign sin_h = s_reg;

endmodule

// ===== hw/rtl/e2q_combine.sv =====
`timescale 1ns / 1ps

module e2q_combine #(
    parameter int SAMPLE_WIDTH = e2q_pkg::SampleWidthDefault
) (
    input  logic                             clk,
    input  logic                             en,
    input  logic signed [e2q_pkg::ProdW-1:0] cr,
    input  logic signed [e2q_pkg::ProdW-1:0] sr,
    input  logic signed [e2q_pkg::ProdW-1:0] cp,
    input  logic signed [e2q_pkg::ProdW-1:0] sp,
    input  logic signed [e2q_pkg::ProdW-1:0] cy,
    input  logic signed [e2q_pkg::ProdW-1:0] sy,
    output logic [SAMPLE_WIDTH-1:0]          qs,
    output logic [SAMPLE_WIDTH-1:0]          qx,
    output logic [SAMPLE_WIDTH-1:0]          qy,
    output logic [SAMPLE_WIDTH-1:0]          qz
);

    localparam int PW = e2q_pkg::ProdW;
    localparam int MW = 2 * PW;
    localparam int SH = 32 - SAMPLE_WIDTH;
    localparam int SW = PW + 2;
    localparam logic signed [SW-1:0] Lim = SW'(64'sd1 <<< (SAMPLE_WIDTH - 2));
    localparam logic signed [SW-1:0] Half = (SH == 0) ? '0 : SW'(64'sd1 <<< (SH - 1));

    // stage 1: pair products cr*cp, sr*cp, cr*sp, sr*sp
    logic signed [PW-1:0] cc_reg, sc_reg, cs_reg, ss_reg;
    logic signed [PW-1:0] cy1_reg, sy1_reg;
    // stage 2: the eight triple products
    logic signed [PW-1:0] t_reg [8];
    logic signed [PW-1:0] t_next [8];
    logic [SAMPLE_WIDTH-1:0] o_reg [4];
    logic [SAMPLE_WIDTH-1:0] o_next [4];

    function automatic logic signed [PW-1:0] mulr(input logic signed [PW-1:0] a,
                                                  input logic signed [PW-1:0] b);
        logic signed [MW-1:0] p;
        begin
            p = MW'(a) * MW'(b) + (MW'(1) <<< 29);
            return PW'(p >>> 30);
        end
    endfunction

    function automatic logic [SAMPLE_WIDTH-1:0] to_out(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] r;
        begin
            r = (v + Half) >>> SH;
            if (r > Lim)
            begin
                r = Lim;
            end
            if (r < -Lim)
            begin
                r = -Lim;
            end
            return r[SAMPLE_WIDTH-1:0];
        end
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cc_reg  <= mulr(cr, cp);
            sc_reg  <= mulr(sr, cp);
            cs_reg  <= mulr(cr, sp);
            ss_reg  <= mulr(sr, sp);
            cy1_reg <= cy;
            sy1_reg <= sy;
        end
    end

    always_comb
    begin
        t_next[0] = mulr(cc_reg, cy1_reg);
        t_next[1] = mulr(ss_reg, sy1_reg);
        t_next[2] = mulr(sc_reg, cy1_reg);
        t_next[3] = mulr(cs_reg, sy1_reg);
        t_next[4] = mulr(cs_reg, cy1_reg);
        t_next[5] = mulr(sc_reg, sy1_reg);
        t_next[6] = mulr(cc_reg, sy1_reg);
        t_next[7] = mulr(ss_reg, cy1_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg <= t_next;
        end
    end

    always_comb
    begin
        o_next[0] = to_out(SW'(t_reg[0]) + SW'(t_reg[1]));
        o_next[1] = to_out(SW'(t_reg[2]) - SW'(t_reg[3]));
        o_next[2] = to_out(SW'(t_reg[4]) + SW'(t_reg[5]));
        o_next[3] = to_out(SW'(t_reg[6]) - SW'(t_reg[7]));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_reg <= o_next;
        end
    end

    assign qs = o_reg[0];
    assign qx = o_reg[1];
    assign qy = o_reg[2];
    assign qz = o_reg[3];

endmodule

// ===== hw/rtl/euler_to_quaternion_core.sv =====
`timescale 1ns / 1ps

// ZYX Euler angles to rotation quaternion. One transfer is taken per cycle
// while the output side does not stall, and each result passes through a
// half-angle range folding stage, a row of 30 CORDIC cells per angle (one
// rotation step per cell), a sign fix-up stage, then two multiply stages
// for the triple products and one stage of rounding and saturation to +-1.0.
// The whole pipe advances when the output register is empty or being taken,
// so a stall on the output side holds every stage in place.
module euler_to_quaternion_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  e2q_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output e2q_pkg::out_item_t  out_data
);

    // sample width is fixed by the transfer types in the package
    localparam int SAMPLE_WIDTH = e2q_pkg::SampleWidthDefault;
    // fold + 30 cells + fix-up + 2 multiply + output
    localparam int Depth = e2q_pkg::CordicSteps + 5;

    logic en;
    logic [Depth-1:0] vld_reg;
    logic [Depth-1:0] vld_next;
    logic signed [e2q_pkg::ProdW-1:0] cr, sr, cp, sp, cy, sy;
    logic [SAMPLE_WIDTH-1:0] qs, qx, qy, qz;

    // pipe moves when the last stage is empty or its transfer completes
    assign en       = !vld_reg[Depth-1] || out_ready;
    assign in_ready = en;
    assign vld_next = {vld_reg[Depth-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    e2q_sincos #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_roll (
        .clk(clk), .en(en), .angle(in_data.roll), .cos_h(cr), .sin_h(sr)
    );
    e2q_sincos #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_pitch (
        .clk(clk), .en(en), .angle(in_data.pitch), .cos_h(cp), .sin_h(sp)
    );
    e2q_sincos #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_yaw (
        .clk(clk), .en(en), .angle(in_data.yaw), .cos_h(cy), .sin_h(sy)
    );

    e2q_combine #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_combine (
        .clk(clk), .en(en),
        .cr(cr), .sr(sr), .cp(cp), .sp(sp), .cy(cy), .sy(sy),
        .qs(qs), .qx(qx), .qy(qy), .qz(qz)
    );

    assign out_valid         = vld_reg[Depth-1];
    assign out_data.q_scalar = qs;
    assign out_data.q_x      = qx;
    assign out_data.q_y      = qy;
    assign out_data.q_z      = qz;

endmodule
